/* rtl/core/asms_pkg.sv */
// ----------------------------------------------------------------------------
// asms_pkg
// Shared constants for the ADC sentence moving-sum block: field widths,
// configuration register indexes and the ASCII codes of the sentence grammar.
// ----------------------------------------------------------------------------
package asms_pkg;

  localparam int CHANNELS     = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_W         = 4;
  localparam int SUM_W        = 21;
  localparam int LEN_FIELD_W  = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int BYTE_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN_0_3    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN_4_7    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN_8_11   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN_12_15  = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;

endpackage

/* rtl/core/asms_if.sv */
// ----------------------------------------------------------------------------
// asms_if
// Valid/ready channels of the ADC sentence moving-sum block: received
// characters, moving-sum results and configuration register writes.
// ----------------------------------------------------------------------------
interface asms_in_if;
  logic                            valid;
  logic                            ready;
  logic [asms_pkg::BYTE_W-1:0]     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface asms_out_if;
  logic                               valid;
  logic                               ready;
  logic [asms_pkg::CH_W-1:0]          channel;
  logic [asms_pkg::SAMPLE_BITS-1:0]   sample;
  logic [asms_pkg::SUM_W-1:0]         window_sum;
  logic                               value_clipped;

  modport source (output valid, output channel, output sample, output window_sum,
                  output value_clipped, input ready);
  modport sink   (input valid, input channel, input sample, input window_sum,
                  input value_clipped, output ready);
endinterface

interface asms_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [asms_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [asms_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/core/adc_sentence_moving_sum.sv */
// ----------------------------------------------------------------------------
// adc_sentence_moving_sum
// Parses "$A<channel>,<value>" sentences from a character stream and keeps a
// per-channel moving sum over a ring buffer of samples held in one memory.
// ----------------------------------------------------------------------------
//   channel   dir  word
//   in_if     in   rx_byte (8)
//   out_if    out  channel (4), sample (16), window_sum (21), value_clipped (1)
//   cfg_if    in   reg_index (3), wdata (24); always ready
//
// A character that ends no sample needs no memory access; one that inserts a
// sample passes the sample memory read and then the write-back.
// After reset the sample memory is swept to zero, one entry a cycle, over all
// 16 * MAX_WINDOW entries (512 by default); in_if.ready stays low meanwhile.
// A result waiting on out_if holds the insert stage, and with it the input.
// ----------------------------------------------------------------------------
module adc_sentence_moving_sum #(
  parameter int MAX_WINDOW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  asms_in_if.sink           in_if,
  asms_out_if.source        out_if,
  asms_cfg_if.sink          cfg_if
);

  localparam int CH    = asms_pkg::CHANNELS;
  localparam int SB    = asms_pkg::SAMPLE_BITS;
  localparam int SW    = asms_pkg::SUM_W;
  localparam int CW    = asms_pkg::CH_W;
  localparam int DEPTH = CH * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW    = 9;
  localparam int VW    = SB + 1;
  localparam int VMW   = VW + 4;

  localparam logic [VW-1:0] VAL_CAP = VW'(1) << SB;

  typedef enum logic [4:0] {
    PH_DISCARD = 5'b00001,
    PH_START   = 5'b00010,
    PH_DOLLAR  = 5'b00100,
    PH_CHAN    = 5'b01000,
    PH_VALUE   = 5'b10000
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [7:0]                      chan_acc_r, chan_acc_nxt;
  logic [VW-1:0]                   val_acc_r, val_acc_nxt;
  logic                            digit_seen_r, digit_seen_nxt;

  logic [CH-1:0]                   en_mask_r;
  logic [asms_pkg::CFG_DATA_W-1:0] wlen_r [4];

  logic [HW-1:0]                   ring_head_r [CH];
  logic [SW-1:0]                   sum_r [CH];
  logic [SB-1:0]                   store_mem [DEPTH];
  logic [SB-1:0]                   rd_data_r;

  logic                            clr_done_r;
  logic [AW-1:0]                   clr_cnt_r;

  logic                            s1_v_r;
  logic [CW-1:0]                   s1_ch_r;
  logic [AW-1:0]                   s1_addr_r;
  logic [SB-1:0]                   s1_data_r;
  logic                            s1_clip_r;

  logic                            out_valid_r;
  logic [CW-1:0]                   out_ch_r;
  logic [SB-1:0]                   out_sample_r;
  logic [SW-1:0]                   out_sum_r;
  logic                            out_clip_r;

  logic                            in_fire;
  logic                            is_digit;
  logic [3:0]                      dval;
  logic [11:0]                     chan_mul;
  logic [VMW-1:0]                  val_mul;
  phase_t                          end_phase;
  logic                            insert_hit;
  logic                            issue;
  logic                            s2_fire;

  logic [CW-1:0]                   ch;
  logic [asms_pkg::CFG_DATA_W-1:0] wlen_word;
  logic [asms_pkg::LEN_FIELD_W-1:0] wlen_field;
  logic [LW-1:0]                   win_len;
  logic [LW-1:0]                   head_inc;
  logic [HW-1:0]                   head_new;
  logic [AW-1:0]                   ins_addr;
  logic                            ins_clip;
  logic [SB-1:0]                   ins_data;
  logic [SW-1:0]                   sum_new;

  logic                            mem_we;
  logic [AW-1:0]                   mem_wa;
  logic [SB-1:0]                   mem_wd;

  assign in_if.ready  = clr_done_r && !s1_v_r;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign is_digit  = (in_if.rx_byte >= asms_pkg::CHAR_ZERO) &&
                     (in_if.rx_byte <= asms_pkg::CHAR_NINE);
  assign dval      = 4'(in_if.rx_byte - asms_pkg::CHAR_ZERO);
  assign chan_mul  = 12'(chan_acc_r) * 12'd10 + 12'(dval);
  assign val_mul   = VMW'(val_acc_r) * VMW'(10) + VMW'(dval);
  assign end_phase = (in_if.rx_byte == asms_pkg::CHAR_NL) ? PH_START : PH_DISCARD;

  always_comb begin
    phase_nxt      = phase_r;
    chan_acc_nxt   = chan_acc_r;
    val_acc_nxt    = val_acc_r;
    digit_seen_nxt = digit_seen_r;
    insert_hit     = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_DISCARD: begin
          if (in_if.rx_byte == asms_pkg::CHAR_NL) phase_nxt = PH_START;
        end
        PH_START: begin
          if (in_if.rx_byte == asms_pkg::CHAR_DOLLAR) phase_nxt = PH_DOLLAR;
          else if (in_if.rx_byte != asms_pkg::CHAR_NL) phase_nxt = PH_DISCARD;
        end
        PH_DOLLAR: begin
          if (in_if.rx_byte == asms_pkg::CHAR_A) begin
            phase_nxt      = PH_CHAN;
            chan_acc_nxt   = '0;
            digit_seen_nxt = 1'b0;
          end else begin
            phase_nxt = end_phase;
          end
        end
        PH_CHAN: begin
          if (is_digit) begin
            chan_acc_nxt   = (chan_mul > 12'd255) ? 8'd255 : chan_mul[7:0];
            digit_seen_nxt = 1'b1;
          end else if (in_if.rx_byte == asms_pkg::CHAR_COMMA && digit_seen_r) begin
            phase_nxt      = PH_VALUE;
            val_acc_nxt    = '0;
            digit_seen_nxt = 1'b0;
          end else begin
            phase_nxt = end_phase;
          end
        end
        PH_VALUE: begin
          if (is_digit) begin
            val_acc_nxt    = (val_mul > VMW'(VAL_CAP)) ? VAL_CAP : val_mul[VW-1:0];
            digit_seen_nxt = 1'b1;
          end else begin
            phase_nxt  = end_phase;
            insert_hit = digit_seen_r && (chan_acc_r < 8'(CH)) &&
                         en_mask_r[chan_acc_r[CW-1:0]];
          end
        end
        default: phase_nxt = PH_DISCARD;
      endcase
    end
  end

  assign issue = in_fire && insert_hit;

  // next ring slot and its memory address
  assign ch        = chan_acc_r[CW-1:0];
  assign wlen_word = wlen_r[ch[3:2]];
  always_comb begin
    case (ch[1:0])
      2'd0:    wlen_field = wlen_word[5:0];
      2'd1:    wlen_field = wlen_word[11:6];
      2'd2:    wlen_field = wlen_word[17:12];
      default: wlen_field = wlen_word[23:18];
    endcase
  end

  always_comb begin
    if (wlen_field == '0) win_len = LW'(1);
    else if (LW'(wlen_field) > LW'(MAX_WINDOW)) win_len = LW'(MAX_WINDOW);
    else win_len = LW'(wlen_field);
  end

  assign head_inc = LW'(ring_head_r[ch]) + LW'(1);
  assign head_new = (head_inc >= win_len) ? '0 : HW'(head_inc);
  assign ins_addr = AW'(ch) * AW'(MAX_WINDOW) + AW'(head_new);
  assign ins_clip = val_acc_r[SB];
  assign ins_data = ins_clip ? '1 : val_acc_r[SB-1:0];

  assign s2_fire = s1_v_r && (!out_valid_r || out_if.ready);
  assign sum_new = sum_r[s1_ch_r] - SW'(rd_data_r) + SW'(s1_data_r);

  assign mem_we = !clr_done_r || s2_fire;
  assign mem_wa = clr_done_r ? s1_addr_r : clr_cnt_r;
  assign mem_wd = clr_done_r ? s1_data_r : '0;

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_wa] <= mem_wd;
    if (issue) rd_data_r <= store_mem[ins_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else if (!clr_done_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) clr_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DISCARD;
      chan_acc_r   <= '0;
      val_acc_r    <= '0;
      digit_seen_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      chan_acc_r   <= chan_acc_nxt;
      val_acc_r    <= val_acc_nxt;
      digit_seen_r <= digit_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_mask_r <= '0;
      for (int i = 0; i < 4; i++) wlen_r[i] <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.reg_index)
        asms_pkg::REG_ENABLE_MASK: en_mask_r <= cfg_if.wdata[CH-1:0];
        asms_pkg::REG_WLEN_0_3:    wlen_r[0] <= cfg_if.wdata;
        asms_pkg::REG_WLEN_4_7:    wlen_r[1] <= cfg_if.wdata;
        asms_pkg::REG_WLEN_8_11:   wlen_r[2] <= cfg_if.wdata;
        asms_pkg::REG_WLEN_12_15:  wlen_r[3] <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  // advance head on issue, fold sum on write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CH; i++) begin
        ring_head_r[i] <= '0;
        sum_r[i]       <= '0;
      end
    end else begin
      if (issue) ring_head_r[ch] <= head_new;
      if (s2_fire) sum_r[s1_ch_r] <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (issue) begin
      s1_v_r <= 1'b1;
    end else if (s2_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ch_r   <= ch;
      s1_addr_r <= ins_addr;
      s1_data_r <= ins_data;
      s1_clip_r <= ins_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_ch_r     <= s1_ch_r;
      out_sample_r <= s1_data_r;
      out_sum_r    <= sum_new;
      out_clip_r   <= s1_clip_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.channel       = out_ch_r;
  assign out_if.sample        = out_sample_r;
  assign out_if.window_sum    = out_sum_r;
  assign out_if.value_clipped = out_clip_r;

`ifndef NO_ASSERTIONS
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !in_if.ready)
    else $error("input accepted during sample memory clear");

  a_issue_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> s1_v_r && !in_if.ready)
    else $error("insert stage not held after issue");

  a_writeback_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire |=> out_if.valid && !s1_v_r)
    else $error("write-back did not produce a result");

  a_stalled_insert_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_fire |=> s1_v_r && $stable(s1_addr_r) && $stable(rd_data_r))
    else $error("stalled insert lost its slot or read data");
`endif

endmodule
